// ===== sv/nmbf_pkg.sv =====
`timescale 1ns / 1ps

package nmbf_pkg;

  localparam int NMBF_BOX_COUNT  = 16;
  localparam int NMBF_RING_DEPTH = 64;
  localparam int NMBF_COUNT_MAX  = 255;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_SEND  = 2'd2,
    CMD_RECV  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    status_t    status;
    logic [3:0] opened;
    logic [6:0] fill;
    logic       wake_send;
    logic       wake_recv;
    logic       rx_ok;
  } res_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== sv/nmbf_store.sv =====
`timescale 1ns / 1ps

module nmbf_store import nmbf_pkg::*; #(
  parameter int DEPTH = NMBF_BOX_COUNT * NMBF_RING_DEPTH
) (
  input  logic                     clk,
  input  mem_ctl_t                 mem_ctl,
  input  logic [$clog2(DEPTH)-1:0] mem_addr,
  input  logic [7:0]               mem_wdata,
  output logic [7:0]               rdata_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  // read data only moves on a committed receive, so it holds under stall
  always_ff @(posedge clk) begin
    if (mem_ctl.re) begin
      rdata_r <= mem[mem_addr];
    end
  end

endmodule

// ===== sv/nmbf_table.sv =====
`timescale 1ns / 1ps

module nmbf_table import nmbf_pkg::*; #(
  parameter int BOX_COUNT  = NMBF_BOX_COUNT,
  parameter int RING_DEPTH = NMBF_RING_DEPTH,
  localparam int BOX_IDX_W = (BOX_COUNT > 1) ? $clog2(BOX_COUNT) : 1,
  localparam int ADDR_W    = $clog2(BOX_COUNT * RING_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              commit,
  input  logic [1:0]        command,
  input  logic [55:0]       name_key,
  input  logic [3:0]        box_index,
  input  logic [7:0]        data_byte,
  input  logic              last_of_message,
  output res_t              res,
  output mem_ctl_t          mem_ctl,
  output logic [ADDR_W-1:0] mem_addr,
  output logic [7:0]        mem_wdata
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int EXT_W = (BOX_IDX_W > 4) ? BOX_IDX_W : 4;

  logic [55:0]      names_r [BOX_COUNT];
  logic [55:0]      names_nxt [BOX_COUNT];
  logic [7:0]       users_r [BOX_COUNT];
  logic [7:0]       users_nxt [BOX_COUNT];
  logic [PTR_W-1:0] rptr_r [BOX_COUNT];
  logic [PTR_W-1:0] rptr_nxt [BOX_COUNT];
  logic [PTR_W-1:0] wptr_r [BOX_COUNT];
  logic [PTR_W-1:0] wptr_nxt [BOX_COUNT];
  logic [CNT_W-1:0] cnt_r [BOX_COUNT];
  logic [CNT_W-1:0] cnt_nxt [BOX_COUNT];

  cmd_t                 cmd;
  logic [EXT_W-1:0]     idx_ext;
  logic                 present;
  logic [BOX_IDX_W-1:0] sel;
  logic                 hit_found;
  logic [BOX_IDX_W-1:0] hit_idx;
  logic                 free_found;
  logic [BOX_IDX_W-1:0] free_idx;
  logic [BOX_IDX_W-1:0] tgt;
  logic [7:0]           tgt_users;
  logic [CNT_W-1:0]     tgt_cnt;
  logic [PTR_W-1:0]     tgt_rptr;
  logic [PTR_W-1:0]     tgt_wptr;
  logic [PTR_W-1:0]     mem_ptr;

  assign cmd     = cmd_t'(command);
  assign idx_ext = EXT_W'(box_index);
  assign present = {1'b0, idx_ext} < (EXT_W + 1)'(BOX_COUNT);
  assign sel     = idx_ext[BOX_IDX_W-1:0];

  // name match and free slot search, lowest index wins
  always_comb begin
    hit_found  = 1'b0;
    hit_idx    = '0;
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < BOX_COUNT; i++) begin
      if (!hit_found && users_r[i] != 8'd0 && names_r[i] == name_key) begin
        hit_found = 1'b1;
        hit_idx   = BOX_IDX_W'(i);
      end
      if (!free_found && users_r[i] == 8'd0) begin
        free_found = 1'b1;
        free_idx   = BOX_IDX_W'(i);
      end
    end
  end

  // one shared read address into the table for the whole command
  assign tgt       = (cmd == CMD_OPEN) ? (hit_found ? hit_idx : free_idx) : sel;
  assign tgt_users = users_r[tgt];
  assign tgt_cnt   = cnt_r[tgt];
  assign tgt_rptr  = rptr_r[tgt];
  assign tgt_wptr  = wptr_r[tgt];

  assign mem_ptr   = (cmd == CMD_SEND) ? tgt_wptr : tgt_rptr;
  assign mem_addr  = ADDR_W'(ADDR_W'(tgt) * ADDR_W'(RING_DEPTH) + ADDR_W'(mem_ptr));
  assign mem_wdata = data_byte;

  always_comb begin
    names_nxt = names_r;
    users_nxt = users_r;
    rptr_nxt  = rptr_r;
    wptr_nxt  = wptr_r;
    cnt_nxt   = cnt_r;
    res       = '0;
    mem_ctl   = '0;
    unique case (cmd)
      CMD_OPEN: begin
        if (hit_found) begin
          if (tgt_users != 8'(NMBF_COUNT_MAX)) begin
            users_nxt[tgt] = tgt_users + 8'd1;
          end
          res.opened = 4'(tgt);
          res.fill   = 7'(tgt_cnt);
        end else if (free_found) begin
          names_nxt[tgt] = name_key;
          rptr_nxt[tgt]  = '0;
          wptr_nxt[tgt]  = '0;
          cnt_nxt[tgt]   = '0;
          users_nxt[tgt] = 8'd1;
          res.opened     = 4'(tgt);
        end else begin
          res.status = ST_NO_FREE;
        end
      end
      CMD_CLOSE: begin
        if (present) begin
          if (tgt_users != 8'd0) begin
            users_nxt[tgt] = tgt_users - 8'd1;
            if (tgt_users == 8'd1) begin
              names_nxt[tgt] = '0;
              res.wake_send  = 1'b1;
              res.wake_recv  = 1'b1;
            end
          end
          res.fill = 7'(tgt_cnt);
        end
      end
      CMD_SEND: begin
        if (!present) begin
          res.status = ST_FULL;
        end else if (tgt_cnt >= CNT_W'(RING_DEPTH)) begin
          res.status = ST_FULL;
          res.fill   = 7'(tgt_cnt);
        end else begin
          mem_ctl.we    = commit;
          wptr_nxt[tgt] = (tgt_wptr == PTR_W'(RING_DEPTH - 1)) ? '0 : tgt_wptr + 1'b1;
          cnt_nxt[tgt]  = tgt_cnt + 1'b1;
          res.fill      = 7'(tgt_cnt + 1'b1);
          res.wake_recv = last_of_message || (tgt_cnt == CNT_W'(RING_DEPTH - 1));
        end
      end
      CMD_RECV: begin
        if (!present || tgt_cnt == '0) begin
          res.status = ST_EMPTY;
        end else begin
          mem_ctl.re    = commit;
          rptr_nxt[tgt] = (tgt_rptr == PTR_W'(RING_DEPTH - 1)) ? '0 : tgt_rptr + 1'b1;
          cnt_nxt[tgt]  = tgt_cnt - 1'b1;
          res.fill      = 7'(tgt_cnt - 1'b1);
          res.wake_send = last_of_message || (tgt_cnt == CNT_W'(1));
          res.rx_ok     = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      names_r <= '{default: '0};
      users_r <= '{default: '0};
      rptr_r  <= '{default: '0};
      wptr_r  <= '{default: '0};
      cnt_r   <= '{default: '0};
    end else if (commit) begin
      names_r <= names_nxt;
      users_r <= users_nxt;
      rptr_r  <= rptr_nxt;
      wptr_r  <= wptr_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== sv/named_mailbox_byte_fifos.sv =====
`timescale 1ns / 1ps

// channel   valid / ready            payload
// in        in_valid / in_ready      in_command, in_name_key, in_box_index,
//                                    in_data_byte, in_last_of_message
// out       out_valid / out_ready    out_status, out_opened_index, out_read_byte,
//                                    out_fill_level, out_wake_senders, out_wake_receivers
//
// one command per cycle sustained while out_ready is high; a taken request passes the
// input register and then the result register; the mailbox table update and the byte
// store access share the one stage after the input register; the popped byte comes
// straight from the store's registered read port; synchronous reset clears the mailbox
// table; the byte store is not cleared; with out_ready low the result and the input
// register both hold, in_ready drops only when both are occupied

module named_mailbox_byte_fifos import nmbf_pkg::*; #(
  parameter int BOX_COUNT  = NMBF_BOX_COUNT,
  parameter int RING_DEPTH = NMBF_RING_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [55:0] in_name_key,
  input  logic [3:0]  in_box_index,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_opened_index,
  output logic [7:0]  out_read_byte,
  output logic [6:0]  out_fill_level,
  output logic        out_wake_senders,
  output logic        out_wake_receivers
);

  localparam int ADDR_W = $clog2(BOX_COUNT * RING_DEPTH);

  logic        a_valid_r;
  logic [1:0]  a_cmd_r;
  logic [55:0] a_key_r;
  logic [3:0]  a_idx_r;
  logic [7:0]  a_data_r;
  logic        a_last_r;
  logic        b_valid_r;
  res_t        b_res_r;

  logic              advance;
  logic              commit;
  res_t              res;
  mem_ctl_t          mem_ctl;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_wdata;
  logic [7:0]        rdata_r;

  assign advance  = !b_valid_r || out_ready;
  assign commit   = a_valid_r && advance;
  assign in_ready = !a_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ready) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_cmd_r  <= in_command;
      a_key_r  <= in_name_key;
      a_idx_r  <= in_box_index;
      a_data_r <= in_data_byte;
      a_last_r <= in_last_of_message;
    end
  end

  nmbf_table #(
    .BOX_COUNT  (BOX_COUNT),
    .RING_DEPTH (RING_DEPTH)
  ) u_table (
    .clk             (clk),
    .rst_n           (rst_n),
    .commit          (commit),
    .command         (a_cmd_r),
    .name_key        (a_key_r),
    .box_index       (a_idx_r),
    .data_byte       (a_data_r),
    .last_of_message (a_last_r),
    .res             (res),
    .mem_ctl         (mem_ctl),
    .mem_addr        (mem_addr),
    .mem_wdata       (mem_wdata)
  );

  nmbf_store #(
    .DEPTH (BOX_COUNT * RING_DEPTH)
  ) u_store (
    .clk       (clk),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .rdata_r   (rdata_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (advance) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      b_res_r <= res;
    end
  end

  assign out_valid          = b_valid_r;
  assign out_status         = b_res_r.status;
  assign out_opened_index   = b_res_r.opened;
  assign out_read_byte      = b_res_r.rx_ok ? rdata_r : 8'd0;
  assign out_fill_level     = b_res_r.fill;
  assign out_wake_senders   = b_res_r.wake_send;
  assign out_wake_receivers = b_res_r.wake_recv;

endmodule

// ===== sv/nmbf_checker.sv =====
`timescale 1ns / 1ps

module nmbf_checker import nmbf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [3:0]  out_opened_index,
  input logic [7:0]  out_read_byte,
  input logic [6:0]  out_fill_level,
  input logic        out_wake_senders,
  input logic        out_wake_receivers
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_read_byte) && $stable(out_fill_level)
      && $stable(out_opened_index))
    else $error("result changed while stalled");

  // out_valid is high once a taken request could pass the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing two cycles after request");

  // failed commands never wake anyone nor deliver a byte
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_wake_senders && !out_wake_receivers
      && out_read_byte == 8'd0)
    else $error("failed command shows side effects");

  // a full table refusal reports no mailbox and no fill
  a_no_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NO_FREE |-> out_opened_index == 4'd0
      && out_fill_level == 7'd0)
    else $error("refused open reports a mailbox");

endmodule

bind named_mailbox_byte_fifos nmbf_checker u_nmbf_checker (.*);

// ===== dv/mailbox_reply_checker.sv =====
`timescale 1ns / 1ps

module mailbox_reply_checker import nmbf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [55:0] in_name_key,
  input  logic [3:0]  in_box_index,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_opened_index,
  input  logic [7:0]  out_read_byte,
  input  logic [6:0]  out_fill_level,
  input  logic        out_wake_senders,
  input  logic        out_wake_receivers,
  output int          mismatch_count,
  output int          replies_owed
);

  localparam int PTR_W = $clog2(NMBF_RING_DEPTH);

  typedef struct packed {
    status_t    status;
    logic [3:0] opened;
    logic [7:0] rbyte;
    logic [6:0] fill;
    logic       wake_send;
    logic       wake_recv;
  } mbox_reply_t;

  logic [55:0]      box_name   [NMBF_BOX_COUNT];
  logic [7:0]       box_users  [NMBF_BOX_COUNT];
  logic [PTR_W-1:0] rd_ptr     [NMBF_BOX_COUNT];
  logic [PTR_W-1:0] wr_ptr     [NMBF_BOX_COUNT];
  logic [6:0]       ring_fill  [NMBF_BOX_COUNT];
  logic [7:0]       ring_bytes [NMBF_BOX_COUNT*NMBF_RING_DEPTH];

  mbox_reply_t awaited_replies[$];

  assign replies_owed = awaited_replies.size();

  function automatic logic [PTR_W-1:0] ring_advance(logic [PTR_W-1:0] p);
    return (p == PTR_W'(NMBF_RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // updates the mailbox table and returns the reply the request should produce
  function automatic mbox_reply_t apply_command(cmd_t op, logic [55:0] key, logic [3:0] idx,
                                                logic [7:0] data, logic last);
    mbox_reply_t r;
    bit found;
    r = '0;
    r.status = ST_OK;
    found = 0;
    case (op)
      CMD_OPEN: begin
        for (int i = 0; i < NMBF_BOX_COUNT; i++) begin
          if (!found && box_users[i] != 0 && box_name[i] == key) begin
            if (box_users[i] != 8'(NMBF_COUNT_MAX)) box_users[i]++;
            r.opened = 4'(i);
            r.fill = ring_fill[i];
            found = 1;
          end
        end
        // no live match: claim the lowest free box
        for (int i = 0; i < NMBF_BOX_COUNT; i++) begin
          if (!found && box_users[i] == 0) begin
            box_name[i] = key;
            rd_ptr[i] = '0;
            wr_ptr[i] = '0;
            ring_fill[i] = '0;
            box_users[i] = 8'd1;
            r.opened = 4'(i);
            found = 1;
          end
        end
        if (!found) r.status = ST_NO_FREE;
      end
      CMD_CLOSE: begin
        if (box_users[idx] != 0) begin
          box_users[idx]--;
          if (box_users[idx] == 0) begin
            box_name[idx] = '0;
            r.wake_send = 1'b1;
            r.wake_recv = 1'b1;
          end
        end
        r.fill = ring_fill[idx];
      end
      CMD_SEND: begin
        if (ring_fill[idx] >= 7'(NMBF_RING_DEPTH)) begin
          r.status = ST_FULL;
          r.fill = ring_fill[idx];
        end else begin
          ring_bytes[idx*NMBF_RING_DEPTH + wr_ptr[idx]] = data;
          wr_ptr[idx] = ring_advance(wr_ptr[idx]);
          ring_fill[idx]++;
          r.fill = ring_fill[idx];
          r.wake_recv = last || (ring_fill[idx] >= 7'(NMBF_RING_DEPTH));
        end
      end
      default: begin
        if (ring_fill[idx] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.rbyte = ring_bytes[idx*NMBF_RING_DEPTH + rd_ptr[idx]];
          rd_ptr[idx] = ring_advance(rd_ptr[idx]);
          ring_fill[idx]--;
          r.fill = ring_fill[idx];
          r.wake_send = last || (ring_fill[idx] == 0);
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    mbox_reply_t got;
    mbox_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < NMBF_BOX_COUNT; i++) begin
        box_name[i] = '0;
        box_users[i] = '0;
        rd_ptr[i] = '0;
        wr_ptr[i] = '0;
        ring_fill[i] = '0;
      end
      awaited_replies.delete();
      mismatch_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.status    = status_t'(out_status);
        got.opened    = out_opened_index;
        got.rbyte     = out_read_byte;
        got.fill      = out_fill_level;
        got.wake_send = out_wake_senders;
        got.wake_recv = out_wake_receivers;
        if (awaited_replies.size() == 0) begin
          if (mismatch_count < 10)
            $display({"%0t: reply with no request outstanding: ",
                      "st=%0d op=%0d rb=%02h fill=%0d ws=%0b wr=%0b"},
                     $realtime, got.status, got.opened, got.rbyte, got.fill, got.wake_send,
                     got.wake_recv);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = awaited_replies.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10)
              $display({"%0t: reply mismatch: ",
                        "expected st=%0d op=%0d rb=%02h fill=%0d ws=%0b wr=%0b, ",
                        "got st=%0d op=%0d rb=%02h fill=%0d ws=%0b wr=%0b"},
                       $realtime, want.status, want.opened, want.rbyte, want.fill,
                       want.wake_send, want.wake_recv, got.status, got.opened, got.rbyte,
                       got.fill, got.wake_send, got.wake_recv);
            mismatch_count <= mismatch_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        awaited_replies.push_back(apply_command(cmd_t'(in_command), in_name_key, in_box_index,
                                                in_data_byte, in_last_of_message));
    end
  end

endmodule

// ===== dv/named_mailbox_byte_fifos_tb.sv =====
`timescale 1ns / 1ps

module named_mailbox_byte_fifos_tb import nmbf_pkg::*;;

  localparam int PHASE_REQUESTS = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_command = '0;
  logic [55:0] in_name_key = '0;
  logic [3:0]  in_box_index = '0;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_opened_index;
  logic [7:0]  out_read_byte;
  logic [6:0]  out_fill_level;
  logic        out_wake_senders;
  logic        out_wake_receivers;
  int          mismatch_count;
  int          replies_owed;

  int          sender_idle_pct = 37;
  int          receiver_stall_pct = 52;
  int          requests_sent = 0;
  logic [55:0] name_pool[8];

  named_mailbox_byte_fifos dut (.*);

  mailbox_reply_checker checker_i (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk)
    out_ready <= (receiver_stall_pct == 0) || ($urandom_range(0, 99) >= receiver_stall_pct);

  function automatic logic [55:0] random_key();
    return 56'({$urandom(), $urandom()});
  endfunction

  // present one request and hold it until the block takes it
  task automatic issue(cmd_t op, logic [55:0] key, logic [3:0] idx, logic [7:0] data,
                       logic last);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= op;
    in_name_key        <= key;
    in_box_index       <= idx;
    in_data_byte       <= data;
    in_last_of_message <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic run_scenario();
    int kind;
    int n;
    int n_rx;
    logic [3:0] b;
    kind = $urandom_range(0, 19);
    b = 4'($urandom_range(0, 15));
    if (kind < 4) begin
      issue(CMD_OPEN, name_pool[$urandom_range(0, 7)], 4'($urandom), 8'($urandom),
            1'($urandom));
    end else if (kind < 5) begin
      issue(CMD_OPEN, random_key(), 4'($urandom), 8'($urandom), 1'($urandom));
    end else if (kind < 10) begin
      // a message pushed then drained, sometimes past empty
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      n_rx = n + $urandom_range(0, 2) - 1;
      for (int i = 0; i < n; i++)
        issue(CMD_SEND, random_key(), b, 8'($urandom), i == n - 1);
      for (int i = 0; i < n_rx; i++)
        issue(CMD_RECV, random_key(), b, 8'($urandom), i == n_rx - 1);
    end else if (kind < 12) begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 16);
      for (int i = 0; i < n; i++)
        issue(CMD_SEND, random_key(), b, 8'($urandom), 1'($urandom_range(0, 3) == 0));
    end else if (kind < 14) begin
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++)
        issue(CMD_RECV, random_key(), b, 8'($urandom), 1'($urandom_range(0, 3) == 0));
    end else if (kind < 16) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        issue(CMD_CLOSE, random_key(), b, 8'($urandom), 1'($urandom));
    end else if (kind < 17) begin
      // run the table out of free boxes, then release one user everywhere
      for (int i = 0; i < 18; i++)
        issue(CMD_OPEN, random_key(), 4'($urandom), 8'($urandom), 1'($urandom));
      for (int i = 0; i < NMBF_BOX_COUNT; i++)
        issue(CMD_CLOSE, random_key(), 4'(i), 8'($urandom), 1'($urandom));
    end else begin
      repeat (3)
        issue(cmd_t'(2'($urandom)), random_key(), 4'($urandom), 8'($urandom),
              1'($urandom));
    end
  endtask

  initial begin
    int target;
    name_pool[0] = '0;
    name_pool[1] = '1;
    for (int i = 2; i < 8; i++) name_pool[i] = random_key();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue(CMD_OPEN,  name_pool[0], 4'd0,  8'h00, 1'b0);
    issue(CMD_OPEN,  name_pool[1], 4'd15, 8'hff, 1'b1);
    issue(CMD_OPEN,  name_pool[0], 4'd3,  8'h5a, 1'b0);
    // closing a box nobody holds
    issue(CMD_CLOSE, '1,           4'd15, 8'h00, 1'b0);
    issue(CMD_SEND,  '0,           4'd0,  8'h00, 1'b0);
    issue(CMD_SEND,  '1,           4'd0,  8'hff, 1'b1);
    issue(CMD_RECV,  '0,           4'd0,  8'h00, 1'b0);
    issue(CMD_RECV,  '0,           4'd0,  8'hff, 1'b0);
    issue(CMD_RECV,  '1,           4'd0,  8'h00, 1'b1);
    // a free box still has a usable ring
    issue(CMD_SEND,  '0,           4'd9,  8'ha5, 1'b0);
    issue(CMD_SEND,  '0,           4'd9,  8'h3c, 1'b0);
    issue(CMD_RECV,  '0,           4'd9,  8'h00, 1'b1);
    issue(CMD_CLOSE, '0,           4'd1,  8'h00, 1'b1);
    issue(CMD_CLOSE, '0,           4'd1,  8'h00, 1'b0);
    issue(CMD_CLOSE, '0,           4'd0,  8'h00, 1'b0);
    issue(CMD_CLOSE, '0,           4'd0,  8'h00, 1'b0);
    issue(CMD_OPEN,  name_pool[2], 4'd7,  8'h81, 1'b1);
    issue(CMD_OPEN,  name_pool[3], 4'd8,  8'h7e, 1'b0);
    issue(CMD_RECV,  '0,           4'd0,  8'h00, 1'b0);
    issue(CMD_SEND,  '1,           4'd15, 8'hff, 1'b1);
    issue(CMD_RECV,  '1,           4'd15, 8'h00, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 52 : 0;
      receiver_stall_pct <= (phase == 0) ? 52 : (phase == 1) ? 37 : 0;
      target = requests_sent + PHASE_REQUESTS;
      // pile users onto one name until its count saturates
      if (phase == 1)
        repeat (258)
          issue(CMD_OPEN, name_pool[4], 4'($urandom), 8'($urandom), 1'($urandom));
      while (requests_sent < target) run_scenario();
    end
    in_valid <= 1'b0;

    while (replies_owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nmbf_pkg.sv
sv/nmbf_store.sv
sv/nmbf_table.sv
sv/named_mailbox_byte_fifos.sv
sv/nmbf_checker.sv
dv/mailbox_reply_checker.sv
dv/named_mailbox_byte_fifos_tb.sv
